// ===== src/mtt_pkg.sv =====
package mtt_pkg;

  localparam int unsigned TimerSlots = 16;
  localparam int unsigned IdW        = 16;
  localparam int unsigned PeriodW    = 32;
  localparam int unsigned RemW       = 33;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_KILL  = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  localparam logic [2:0] KIND_SET    = 3'd0;
  localparam logic [2:0] KIND_KILL   = 3'd1;
  localparam logic [2:0] KIND_EXPIRY = 3'd2;
  localparam logic [2:0] KIND_START  = 3'd3;
  localparam logic [2:0] KIND_STOP   = 3'd4;
  localparam logic [2:0] KIND_DONE   = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] timer_id;
    logic [31:0] interval_ms;
    logic        repeat_req;
    logic [15:0] elapsed_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] result_id;
    logic        ok;
    logic        last;
  } rsp_t;

  // one timer slot as stored in the table memory
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] period;
    logic        periodic;
    logic [32:0] remaining;
  } slot_t;

endpackage

// ===== src/mtt_table.sv =====
module mtt_table #(
  parameter int unsigned Slots = mtt_pkg::TimerSlots,
  localparam int unsigned AW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output mtt_pkg::slot_t       rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  mtt_pkg::slot_t       wr_data_i
);

  mtt_pkg::slot_t mem [Slots];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ===== src/multi_timer_table.sv =====
// multi_timer_table: table of one-shot and periodic timers kept in a slot memory.
// Stop and refused requests answer straight from idle; kill, zero-interval set and start
//   make one scan of the memory; set makes one scan plus one more per id collision, then
//   a write; tick makes one subtracting scan, then one expiry per scan of the memory.
// One request at a time; busy stays high until the final result, which the
//   receiver cannot stall. Reset (rst_ni low, asynchronous) empties the table, next id 1.
module multi_timer_table #(
  parameter int unsigned TimerSlots = mtt_pkg::TimerSlots
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mtt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output mtt_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned CW = $clog2(TimerSlots + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_ALLOC, S_WRITE, S_TICK, S_EMIT, S_START
  } state_e;

  state_e state_q;
  mtt_pkg::req_t req_q;
  logic [TimerSlots-1:0] valid_q, due_q;
  logic [CW-1:0] idx_q;        // slot being issued to the memory
  logic          rd_pend_q;    // read data of slot idx_q-1 arrives this cycle
  logic [AW-1:0] rd_slot_q;
  logic [15:0]   next_id_q, cand_q;
  logic          running_q, stopped_q;
  logic          hit_q, free_found_q, collide_q;
  logic [AW-1:0] hit_slot_q, free_slot_q;
  // running minimum of due ids during an emit pass
  logic          best_v_q;
  logic [AW-1:0] best_slot_q;
  mtt_pkg::slot_t best_q;

  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  mtt_pkg::slot_t rd_data, wr_data;

  mtt_table #(.Slots(TimerSlots)) u_table (
    .clk_i, .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  assign busy = (state_q != S_IDLE);

  logic issue;
  assign issue = (idx_q < CW'(TimerSlots));
  assign rd_addr = idx_q[AW-1:0];

  // tick arithmetic on the slot just read
  logic signed [32:0] rem_sub;
  assign rem_sub = $signed(rd_data.remaining) - $signed({17'd0, req_q.elapsed_ms});
  // expiry reload of the chosen slot
  logic signed [33:0] rem_add;
  assign rem_add = $signed({best_q.remaining[32], best_q.remaining})
                 + $signed({2'b00, best_q.period});

  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    wr_addr = rd_slot_q;
    wr_data = rd_data;
    unique case (state_q)
      S_FIND, S_TICK, S_START, S_EMIT: rd_en = issue;
      default: ;
    endcase
    if (rd_pend_q && valid_q[rd_slot_q]) begin
      unique case (state_q)
        S_TICK: if (running_q) begin
          wr_en = 1'b1;
          wr_data.remaining = rem_sub;
        end
        S_START: begin
          wr_en = 1'b1;
          wr_data.remaining = {1'b0, rd_data.period};
        end
        default: ;
      endcase
    end
    if (state_q == S_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = hit_q ? hit_slot_q : free_slot_q;
      wr_data.id        = cand_q;
      wr_data.period    = req_q.interval_ms;
      wr_data.periodic  = req_q.repeat_req;
      wr_data.remaining = {1'b0, req_q.interval_ms};
    end
    if (state_q == S_EMIT && !rd_pend_q && !issue && best_v_q && best_q.periodic) begin
      // reload; resync to the full period when still due
      wr_en   = 1'b1;
      wr_addr = best_slot_q;
      wr_data = best_q;
      wr_data.remaining = (rem_add <= 0) ? {1'b0, best_q.period} : rem_add[32:0];
    end
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    logic [15:0] n;
    n = v + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      due_q       <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_slot_q   <= '0;
      next_id_q   <= 16'd1;
      cand_q      <= '0;
      running_q   <= 1'b0;
      stopped_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_found_q <= 1'b0;
      collide_q   <= 1'b0;
      hit_slot_q  <= '0;
      free_slot_q <= '0;
      best_v_q    <= 1'b0;
      best_slot_q <= '0;
      best_q      <= '0;
      rsp_valid_o <= 1'b0;
      rsp_o       <= '0;
      req_q       <= '0;
    end else begin
      rsp_valid_o <= 1'b0;
      rd_pend_q   <= rd_en;
      rd_slot_q   <= rd_addr;
      if (rd_en) idx_q <= idx_q + CW'(1);
      unique case (state_q)
        S_IDLE: if (start) begin
          req_q        <= req_i;
          idx_q        <= '0;
          rd_pend_q    <= 1'b0;
          hit_q        <= 1'b0;
          free_found_q <= 1'b0;
          collide_q    <= 1'b0;
          best_v_q     <= 1'b0;
          due_q        <= '0;
          cand_q       <= (req_i.timer_id != 16'd0) ? req_i.timer_id
                        : ((next_id_q == 16'd0) ? 16'd1 : next_id_q);
          case (req_i.operation)
            mtt_pkg::OP_SET: begin
              if (req_i.interval_ms == 32'd0 && req_i.timer_id == 16'd0) begin
                rsp_valid_o <= 1'b1;
                rsp_o <= '{kind: mtt_pkg::KIND_SET, result_id: 16'd0, ok: 1'b0, last: 1'b1};
              end else if (req_i.interval_ms != 32'd0 && stopped_q) begin
                rsp_valid_o <= 1'b1;
                rsp_o <= '{kind: mtt_pkg::KIND_SET, result_id: 16'd0, ok: 1'b0, last: 1'b1};
              end else state_q <= S_FIND;
            end
            mtt_pkg::OP_KILL: begin
              if (req_i.timer_id == 16'd0) begin
                rsp_valid_o <= 1'b1;
                rsp_o <= '{kind: mtt_pkg::KIND_KILL, result_id: 16'd0, ok: 1'b0, last: 1'b1};
              end else state_q <= S_FIND;
            end
            mtt_pkg::OP_TICK:  state_q <= S_TICK;
            mtt_pkg::OP_START: begin
              if (running_q) begin
                rsp_valid_o <= 1'b1;
                rsp_o <= '{kind: mtt_pkg::KIND_START, result_id: 16'd0, ok: 1'b0, last: 1'b1};
              end else state_q <= S_START;
            end
            mtt_pkg::OP_STOP: begin
              stopped_q   <= 1'b1;
              running_q   <= 1'b0;
              rsp_valid_o <= 1'b1;
              rsp_o <= '{kind: mtt_pkg::KIND_STOP, result_id: 16'd0, ok: 1'b1, last: 1'b1};
            end
            default: ;
          endcase
        end
        S_FIND: begin
          // scan for cand_q and the first free slot
          if (rd_pend_q) begin
            if (!valid_q[rd_slot_q]) begin
              if (!free_found_q) begin
                free_found_q <= 1'b1;
                free_slot_q  <= rd_slot_q;
              end
            end else if (rd_data.id == cand_q) begin
              hit_q      <= 1'b1;
              hit_slot_q <= rd_slot_q;
              collide_q  <= 1'b1;
            end
          end else if (!issue) begin
            if (req_q.operation == mtt_pkg::OP_KILL || req_q.interval_ms == 32'd0) begin
              if (hit_q) valid_q[hit_slot_q] <= 1'b0;
              rsp_valid_o <= 1'b1;
              if (req_q.operation == mtt_pkg::OP_KILL) begin
                rsp_o <= '{kind: mtt_pkg::KIND_KILL, result_id: 16'd0, ok: hit_q, last: 1'b1};
              end else begin
                rsp_o <= '{kind: mtt_pkg::KIND_SET, result_id: 16'd0, ok: 1'b0, last: 1'b1};
              end
              state_q <= S_IDLE;
            end else if (req_q.timer_id != 16'd0) begin
              if (hit_q || free_found_q) state_q <= S_WRITE;
              else begin
                rsp_valid_o <= 1'b1;
                rsp_o <= '{kind: mtt_pkg::KIND_SET, result_id: 16'd0, ok: 1'b0, last: 1'b1};
                state_q <= S_IDLE;
              end
            end else if (!free_found_q) begin
              rsp_valid_o <= 1'b1;
              rsp_o <= '{kind: mtt_pkg::KIND_SET, result_id: 16'd0, ok: 1'b0, last: 1'b1};
              state_q <= S_IDLE;
            end else if (collide_q) begin
              // candidate in use: try the next id with another pass
              cand_q    <= bump(cand_q);
              collide_q <= 1'b0;
              hit_q     <= 1'b0;
              idx_q     <= '0;
            end else state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          valid_q[hit_q ? hit_slot_q : free_slot_q] <= 1'b1;
          if (req_q.timer_id == 16'd0) next_id_q <= bump(cand_q);
          rsp_valid_o <= 1'b1;
          rsp_o <= '{kind: mtt_pkg::KIND_SET, result_id: cand_q, ok: 1'b1, last: 1'b1};
          state_q <= S_IDLE;
        end
        S_TICK: begin
          if (rd_pend_q && valid_q[rd_slot_q] && running_q)
            due_q[rd_slot_q] <= (rem_sub <= 0);
          if (!rd_pend_q && !issue) begin
            idx_q    <= '0;
            best_v_q <= 1'b0;
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          // pick the smallest due id, one pass per expiry
          if (rd_pend_q) begin
            if (due_q[rd_slot_q] && (!best_v_q || rd_data.id < best_q.id)) begin
              best_v_q    <= 1'b1;
              best_q      <= rd_data;
              best_slot_q <= rd_slot_q;
            end
          end else if (!issue) begin
            rsp_valid_o <= 1'b1;
            if (best_v_q) begin
              rsp_o <= '{kind: mtt_pkg::KIND_EXPIRY, result_id: best_q.id, ok: 1'b1,
                         last: 1'b0};
              due_q[best_slot_q] <= 1'b0;
              if (!best_q.periodic) valid_q[best_slot_q] <= 1'b0;
              best_v_q <= 1'b0;
              idx_q    <= '0;
            end else begin
              rsp_o <= '{kind: mtt_pkg::KIND_DONE, result_id: 16'd0, ok: 1'b0, last: 1'b1};
              state_q <= S_IDLE;
            end
          end
        end
        S_START: if (!rd_pend_q && !issue) begin
          running_q   <= 1'b1;
          stopped_q   <= 1'b0;
          rsp_valid_o <= 1'b1;
          rsp_o <= '{kind: mtt_pkg::KIND_START, result_id: 16'd0, ok: 1'b1, last: 1'b1};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_run_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(running_q && stopped_q)) else $error("running and stopped both set");
  a_last_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.last) |-> !busy) else $error("busy after final result");
  a_next_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != 16'd0) else $error("next id zero");
  a_due_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q & ~valid_q) == '0) else $error("due slot not valid");

endmodule

// ===== sim/tb_multi_timer_table.sv =====
module tb_multi_timer_table;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned QuietStart = 200;
  localparam int unsigned QuietEnd   = 320;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  mtt_pkg::req_t  req_i = '0;
  logic  rsp_valid_o;
  mtt_pkg::rsp_t  rsp_o;

  multi_timer_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the timer table, updated as each request is accepted.
  bit          slot_used     [mtt_pkg::TimerSlots];
  logic [15:0] slot_id       [mtt_pkg::TimerSlots];
  logic [31:0] slot_period   [mtt_pkg::TimerSlots];
  bit          slot_periodic [mtt_pkg::TimerSlots];
  longint      slot_left     [mtt_pkg::TimerSlots];
  logic [15:0] alloc_next = 16'd1;
  bit          is_running = 1'b0;
  bit          is_stopped = 1'b0;

  mtt_pkg::req_t pending_reqs[$];
  bit   drain_first[$];
  mtt_pkg::rsp_t expected_rsps[$];

  int unsigned reqs_sent = 0;
  int unsigned rsps_seen = 0;
  int unsigned expiries_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  initial begin
    for (int i = 0; i < mtt_pkg::TimerSlots; i++) slot_used[i] = 1'b0;
  end

  function automatic int find_timer(logic [15:0] id);
    for (int i = 0; i < mtt_pkg::TimerSlots; i++)
      if (slot_used[i] && slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int find_empty();
    for (int i = 0; i < mtt_pkg::TimerSlots; i++)
      if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic logic [15:0] next_id(logic [15:0] v);
    logic [15:0] n;
    n = v + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  function automatic bit drop_timer(logic [15:0] id);
    int s;
    if (id == 16'd0) return 1'b0;
    s = find_timer(id);
    if (s < 0) return 1'b0;
    slot_used[s] = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] program_timer(mtt_pkg::req_t r);
    int          s;
    logic [15:0] id;
    bit          dummy;
    id = r.timer_id;
    if (r.interval_ms == 32'd0) begin
      dummy = drop_timer(id);
      return 16'd0;
    end
    if (is_stopped) return 16'd0;
    if (id == 16'd0) begin
      s = find_empty();
      if (s < 0) return 16'd0;
      id = (alloc_next == 16'd0) ? 16'd1 : alloc_next;
      while (find_timer(id) >= 0) id = next_id(id);
      alloc_next = next_id(id);
    end else begin
      s = find_timer(id);
      if (s < 0) s = find_empty();
      if (s < 0) return 16'd0;
    end
    slot_used[s]     = 1'b1;
    slot_id[s]       = id;
    slot_period[s]   = r.interval_ms;
    slot_periodic[s] = r.repeat_req;
    slot_left[s]     = longint'(r.interval_ms);
    return id;
  endfunction

  function automatic mtt_pkg::rsp_t mk_rsp(logic [2:0] kind, logic [15:0] id, logic ok);
    mtt_pkg::rsp_t r;
    r.kind = kind;
    r.result_id = id;
    r.ok = ok;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out every reply a request causes and append them to the expected list.
  function automatic void predict_replies(mtt_pkg::req_t r);
    mtt_pkg::rsp_t out[$];
    bit          due[mtt_pkg::TimerSlots];
    int          pick;
    logic [15:0] got;
    case (r.operation)
      mtt_pkg::OP_SET: begin
        got = program_timer(r);
        out = {out, mk_rsp(mtt_pkg::KIND_SET, got, got != 16'd0)};
      end
      mtt_pkg::OP_KILL:
        out = {out, mk_rsp(mtt_pkg::KIND_KILL, 16'd0, drop_timer(r.timer_id))};
      mtt_pkg::OP_TICK: begin
        for (int i = 0; i < mtt_pkg::TimerSlots; i++) begin
          due[i] = 1'b0;
          if (is_running && slot_used[i]) begin
            slot_left[i] -= longint'(r.elapsed_ms);
            due[i] = slot_left[i] <= 0;
          end
        end
        // report due timers lowest id first
        forever begin
          pick = -1;
          for (int i = 0; i < mtt_pkg::TimerSlots; i++)
            if (due[i] && (pick < 0 || slot_id[i] < slot_id[pick])) pick = i;
          if (pick < 0) break;
          due[pick] = 1'b0;
          out = {out, mk_rsp(mtt_pkg::KIND_EXPIRY, slot_id[pick], 1'b1)};
          if (slot_periodic[pick]) begin
            slot_left[pick] += longint'(slot_period[pick]);
            // missed more than one period: resync instead of catching up
            if (slot_left[pick] <= 0) slot_left[pick] = longint'(slot_period[pick]);
          end else begin
            slot_used[pick] = 1'b0;
          end
        end
        out = {out, mk_rsp(mtt_pkg::KIND_DONE, 16'd0, 1'b0)};
      end
      mtt_pkg::OP_START: begin
        if (is_running) begin
          out = {out, mk_rsp(mtt_pkg::KIND_START, 16'd0, 1'b0)};
        end else begin
          is_running = 1'b1;
          is_stopped = 1'b0;
          for (int i = 0; i < mtt_pkg::TimerSlots; i++)
            if (slot_used[i]) slot_left[i] = longint'(slot_period[i]);
          out = {out, mk_rsp(mtt_pkg::KIND_START, 16'd0, 1'b1)};
        end
      end
      mtt_pkg::OP_STOP: begin
        is_stopped = 1'b1;
        is_running = 1'b0;
        out = {out, mk_rsp(mtt_pkg::KIND_STOP, 16'd0, 1'b1)};
      end
      default: ;  // undefined codes produce nothing
    endcase
    if (out.size() > 0) out[out.size()-1].last = 1'b1;
    expected_rsps = {expected_rsps, out};
  endfunction

  // Request driver: hold start and the request until busy is low at an edge.
  always @(posedge clk_i or negedge rst_ni) begin
    bit accepted;
    bit idle;
    bit blocked;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        predict_replies(req_i);
        reqs_sent++;
      end
      if (accepted || !start) begin
        idle = (reqs_sent < QuietStart || reqs_sent >= QuietEnd) &&
               ($urandom_range(99) < 7);
        blocked = pending_reqs.size() == 0 || idle ||
                  (drain_first[0] && expected_rsps.size() != 0);
        if (blocked) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          req_i <= pending_reqs.pop_front();
          void'(drain_first.pop_front());
        end
      end
    end
  end

  // Reply monitor: compare each strobed reply with the oldest expectation.
  always @(posedge clk_i) begin
    mtt_pkg::rsp_t exp_rsp;
    if (rst_ni && rsp_valid_o) begin
      rsps_seen++;
      if (rsp_o.kind == mtt_pkg::KIND_EXPIRY) expiries_seen++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected reply kind=%0d id=%0d", rsp_o.kind, rsp_o.result_id);
        mismatches++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp_o.kind !== exp_rsp.kind) begin
          $error("kind: expected %0d actual %0d", exp_rsp.kind, rsp_o.kind);
          mismatches++;
        end
        if (rsp_o.result_id !== exp_rsp.result_id) begin
          $error("result_id: expected %0d actual %0d", exp_rsp.result_id, rsp_o.result_id);
          mismatches++;
        end
        if (rsp_o.ok !== exp_rsp.ok) begin
          $error("ok: expected %0d actual %0d", exp_rsp.ok, rsp_o.ok);
          mismatches++;
        end
        if (rsp_o.last !== exp_rsp.last) begin
          $error("last: expected %0d actual %0d", exp_rsp.last, rsp_o.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_req(logic [2:0] op, logic [15:0] id, logic [31:0] iv,
                           logic rep, logic [15:0] el, bit drain);
    mtt_pkg::req_t r;
    r.operation = op;
    r.timer_id = id;
    r.interval_ms = iv;
    r.repeat_req = rep;
    r.elapsed_ms = el;
    pending_reqs = {pending_reqs, r};
    drain_first = {drain_first, drain};
  endtask

  // Draw one random request, biased toward short timers on a small id pool.
  task automatic queue_random();
    int unsigned sel;
    logic [2:0]  op;
    logic [15:0] id;
    logic [31:0] iv;
    logic [15:0] el;
    sel = $urandom_range(99);
    if (sel < 36)      op = mtt_pkg::OP_SET;
    else if (sel < 46) op = mtt_pkg::OP_KILL;
    else if (sel < 82) op = mtt_pkg::OP_TICK;
    else if (sel < 92) op = mtt_pkg::OP_START;
    else if (sel < 97) op = mtt_pkg::OP_STOP;
    else               op = 3'($urandom_range(7, 5));
    sel = $urandom_range(9);
    if (sel < 2)       id = 16'd0;
    else if (sel < 8)  id = 16'($urandom_range(24, 1));
    else               id = 16'($urandom);
    sel = $urandom_range(19);
    if (sel == 0)      iv = 32'd0;
    else if (sel == 1) iv = 32'($urandom);
    else if (sel == 2) iv = 32'hFFFF_FFFF;
    else               iv = 32'($urandom_range(400, 1));
    sel = $urandom_range(19);
    if (sel == 0)      el = 16'($urandom);
    else if (sel == 1) el = 16'hFFFF;
    else               el = 16'($urandom_range(150));
    queue_req(op, id, iv, 1'($urandom), el, $urandom_range(49) == 0);
  endtask

  initial begin
    // directed: idle-table corners, extremes and the refusal paths
    queue_req(mtt_pkg::OP_TICK, 16'd0, 32'd0, 1'b0, 16'hFFFF, 1'b0);  // not running yet
    queue_req(mtt_pkg::OP_KILL, 16'd0, 32'd0, 1'b0, 16'd0, 1'b0);     // kill of id zero
    queue_req(mtt_pkg::OP_KILL, 16'hFFFF, 32'd0, 1'b0, 16'd0, 1'b0);  // kill of absent id
    queue_req(mtt_pkg::OP_START, 16'd0, 32'd0, 1'b0, 16'd0, 1'b0);
    queue_req(mtt_pkg::OP_START, 16'd0, 32'd0, 1'b0, 16'd0, 1'b0);    // already running
    queue_req(mtt_pkg::OP_SET, 16'd0, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0);
    queue_req(mtt_pkg::OP_SET, 16'hFFFF, 32'd3, 1'b1, 16'd0, 1'b0);
    queue_req(mtt_pkg::OP_SET, 16'd7, 32'd10, 1'b0, 16'd0, 1'b0);
    queue_req(mtt_pkg::OP_SET, 16'd7, 32'd0, 1'b0, 16'd0, 1'b0);      // zero interval kills
    queue_req(mtt_pkg::OP_TICK, 16'd0, 32'd0, 1'b0, 16'd20, 1'b0);    // periodic resync
    queue_req(mtt_pkg::OP_TICK, 16'd0, 32'd0, 1'b0, 16'hFFFF, 1'b0);
    // fill the table, then one more set must be refused
    for (int i = 0; i < 15; i++)
      queue_req(mtt_pkg::OP_SET, 16'd0, 32'(5 + i), 1'(i), 16'd0, 1'b0);
    queue_req(mtt_pkg::OP_SET, 16'd0, 32'd9, 1'b0, 16'd0, 1'b1);
    queue_req(mtt_pkg::OP_TICK, 16'd0, 32'd0, 1'b0, 16'd12, 1'b0);
    queue_req(mtt_pkg::OP_STOP, 16'd0, 32'd0, 1'b0, 16'd0, 1'b0);
    queue_req(mtt_pkg::OP_SET, 16'd3, 32'd5, 1'b0, 16'd0, 1'b0);     // refused while stopped
    queue_req(mtt_pkg::OP_TICK, 16'd0, 32'd0, 1'b0, 16'd100, 1'b0);
    queue_req(3'd5, 16'd0, 32'd0, 1'b0, 16'd0, 1'b0);
    queue_req(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b0);
    queue_req(mtt_pkg::OP_START, 16'd0, 32'd0, 1'b0, 16'd0, 1'b1);
    for (int i = 0; i < 440; i++) queue_random();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the queue to empty and every reply to arrive
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("requests issued: %0d, replies checked: %0d, timer expiries: %0d",
             reqs_sent, rsps_seen, expiries_seen);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mtt_pkg.sv
src/mtt_table.sv
src/multi_timer_table.sv
sim/tb_multi_timer_table.sv
